### sv/factorial_prime_exponent_top_defines.svh
// Assertion macros for the factorial prime exponent block.
// Used by the port checker; relies on clk_i and rst_ni in the scope of use.
`ifndef FACTORIAL_PRIME_EXPONENT_TOP_DEFINES_SVH
`define FACTORIAL_PRIME_EXPONENT_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/fpe_pkg.sv
// Shared types and constants for the factorial prime exponent block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fpe_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;

  // How a result is formed when the controller finishes an item.
  typedef enum logic [1:0] {
    FIN_SUM,
    FIN_ZERO,
    FIN_ONE,
    FIN_BAD
  } fin_e;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic acc_add;
    logic finish;
    fin_e fin_code;
  } cmd_t;

  typedef struct packed {
    logic base_bad;
    logic base_gt_num;
    logic base_gt_half;
    logic div_last;
    logic quot_ge_base;
    logic out_free;
  } sts_t;

endpackage

### sv/fpe_ctrl.sv
// Controller for the factorial prime exponent block.
// Sequences checks, divisions and accumulation; uses fpe_pkg command/status types.
`timescale 1ns / 1ps

module fpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpe_pkg::sts_t sts_i,
  output fpe_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_TEST
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.fin_code  = fpe_pkg::FIN_SUM;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // The shortcut results wait here until the output register is free.
        if (sts_i.base_bad || sts_i.base_gt_num || sts_i.base_gt_half) begin
          if (sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            if (sts_i.base_bad) begin
              cmd_o.fin_code = fpe_pkg::FIN_BAD;
            end else if (sts_i.base_gt_num) begin
              cmd_o.fin_code = fpe_pkg::FIN_ZERO;
            end else begin
              cmd_o.fin_code = fpe_pkg::FIN_ONE;
            end
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_TEST;
      end
      ST_TEST: begin
        if (sts_i.quot_ge_base) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else if (sts_i.out_free) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_code = fpe_pkg::FIN_SUM;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

### sv/fpe_dp.sv
// Datapath for the factorial prime exponent block: radix-2 restoring divider,
// running sum and output register. Uses fpe_pkg command/status types.
`timescale 1ns / 1ps

module fpe_dp #(
  parameter int unsigned WORD_BITS = fpe_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WORD_BITS-1:0] number_i,
  input  logic [WORD_BITS-1:0] base_prime_i,
  input  fpe_pkg::cmd_t        cmd_i,
  output fpe_pkg::sts_t        sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] exponent_o,
  output logic                 bad_base_o
);

  localparam int unsigned CntW = $clog2(WORD_BITS);
  localparam logic [CntW-1:0] LastCnt = CntW'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] base_q;
  logic [WORD_BITS-1:0] dvd_q, dvd_d;   // dividend, shifted out as quotient shifts in
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] acc_q;
  logic [CntW-1:0]      cnt_q;
  logic [WORD_BITS-1:0] exp_q, exp_d;
  logic                 bad_q, bad_d;
  logic                 out_valid_q, out_valid_d;

  logic [WORD_BITS:0]   rem_ext;
  logic [WORD_BITS:0]   rem_sub;
  logic                 fits;

  // One restoring division step.
  always_comb begin
    rem_ext = {rem_q, dvd_q[WORD_BITS-1]};
    fits    = (rem_ext >= {1'b0, base_q});
    rem_sub = rem_ext - {1'b0, base_q};
    rem_d   = fits ? rem_sub[WORD_BITS-1:0] : rem_ext[WORD_BITS-1:0];
    dvd_d   = {dvd_q[WORD_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_prime_i;
      dvd_q  <= number_i;
      acc_q  <= '0;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.acc_add) begin
      acc_q <= acc_q + dvd_q;
    end
  end

  always_comb begin
    exp_d       = exp_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      bad_d       = (cmd_i.fin_code == fpe_pkg::FIN_BAD);
      case (cmd_i.fin_code)
        fpe_pkg::FIN_SUM:  exp_d = acc_q;
        fpe_pkg::FIN_ONE:  exp_d = WORD_BITS'(1);
        fpe_pkg::FIN_ZERO: exp_d = '0;
        fpe_pkg::FIN_BAD:  exp_d = '0;
        default:           exp_d = '0;
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    bad_q <= bad_d;
  end

  // After loading, dvd_q holds the number; after a division, the quotient.
  assign sts_o.base_bad     = (base_q < WORD_BITS'(2));
  assign sts_o.base_gt_num  = (base_q > dvd_q);
  assign sts_o.base_gt_half = (base_q > (dvd_q >> 1));
  assign sts_o.div_last     = (cnt_q == LastCnt);
  assign sts_o.quot_ge_base = (dvd_q >= base_q);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign exponent_o  = exp_q;
  assign bad_base_o  = bad_q;

endmodule

### sv/factorial_prime_exponent_top.sv
// Top level of the factorial prime exponent block (Legendre's formula).
// Instantiates fpe_ctrl and fpe_dp; types and defaults come from fpe_pkg.
//
// Usage: an item (number_i, base_prime_i) enters on the in channel
// (in_valid_i/in_ready_o) and yields one result item (exponent_o, bad_base_o)
// on the out channel (out_valid_o/out_ready_i). One item is worked at a time;
// in_ready_o is high only while the block is waiting for a new item.
// A base of 0 or 1 gives exponent 0 with bad_base set; a base above the
// number gives 0, a base above half the number gives 1, each loaded into
// the output register once it is free. Otherwise the block divides
// repeatedly with a radix-2 restoring divider, adding each quotient to a
// running sum and testing it against the base, over k = floor(log_base(number))
// quotients; base 2 with the largest number needs the most. The single shared
// divider handles one item at a time; a new item is taken only after the
// previous result is loaded. The result sits in an output register; while
// the receiver stalls, the block may accept and work on the next item, but
// holds its result until the register frees. Reset clears the controller
// and the output valid.
`timescale 1ns / 1ps

module factorial_prime_exponent_top #(
  parameter int unsigned WORD_BITS = fpe_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] number_i,
  input  logic [WORD_BITS-1:0] base_prime_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] exponent_o,
  output logic                 bad_base_o
);

  fpe_pkg::cmd_t cmd;
  fpe_pkg::sts_t sts;

  fpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpe_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .number_i     (number_i),
    .base_prime_i (base_prime_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .exponent_o   (exponent_o),
    .bad_base_o   (bad_base_o)
  );

endmodule

### sv/fpe_checker.sv
// Port-level checker for the factorial prime exponent block, bound to the top.
// Depends on factorial_prime_exponent_top_defines.svh and fpe_pkg.
`timescale 1ns / 1ps
`include "factorial_prime_exponent_top_defines.svh"

module fpe_checker #(
  parameter int unsigned WORD_BITS = fpe_pkg::WORD_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [WORD_BITS-1:0] exponent_o,
  input logic                 bad_base_o
);

  // A bad base always reports a zero exponent.
  `FPE_ASSERT(a_bad_base_zero, (out_valid_o && bad_base_o) |-> (exponent_o == '0), "bad base with nonzero exponent")

  // The block works one item at a time, so it is busy right after accepting.
  `FPE_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "accepted a second item while busy")

  // A stalled result holds its value.
  `FPE_ASSERT(a_result_holds, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(exponent_o) && $stable(bad_base_o)), "stalled result changed")

  // Once reset has been seen at an edge, nothing is offered at the next one.
  `FPE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind factorial_prime_exponent_top fpe_checker #(.WORD_BITS(WORD_BITS)) u_fpe_checker (.*);

### test/tb_factorial_prime_exponent_top.sv
// Self-checking testbench for factorial_prime_exponent_top (Legendre exponent of a base in n!).
// Depends on fpe_pkg and the block's RTL; a driver and a monitor with random idling check each
// result against an in-bench predictor.
`timescale 1ns / 1ps

module tb_factorial_prime_exponent_top;

  localparam int unsigned W = fpe_pkg::WORD_BITS_DEF;
  localparam logic [W-1:0] WORD_MAX = '1;

  // Cycles the block may still need for one item in the worst case (base 2, largest number).
  localparam int unsigned ITEM_LATENCY = 1100;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct {
    logic [W-1:0] number;
    logic [W-1:0] base;
    bit           drain;
  } pend_item_t;

  typedef struct {
    logic [W-1:0] exponent;
    logic         bad_base;
  } exp_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [W-1:0] number_i = '0;
  logic [W-1:0] base_prime_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [W-1:0] exponent_o;
  logic         bad_base_o;

  pend_item_t  pend_q[$];
  exp_result_t exp_q[$];

  int unsigned total_items = 0;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  factorial_prime_exponent_top #(
    .WORD_BITS(W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .number_i    (number_i),
    .base_prime_i(base_prime_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .exponent_o  (exponent_o),
    .bad_base_o  (bad_base_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sum of repeated quotients, with the base check and both shortcuts ahead of the loop.
  function automatic exp_result_t legendre_exponent(input logic [W-1:0] n, input logic [W-1:0] b);
    exp_result_t  r;
    logic [W-1:0] quot;
    r.exponent = '0;
    r.bad_base = 1'b0;
    quot = n;
    if (b < 2) begin
      r.bad_base = 1'b1;
    end else if (b > n) begin
      r.exponent = '0;
    end else if (b > (n >> 1)) begin
      r.exponent = 1;
    end else begin
      while (quot >= b) begin
        quot = quot / b;
        r.exponent = r.exponent + quot;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic add_item(input logic [W-1:0] n, input logic [W-1:0] b, input bit drain);
    pend_item_t it;
    it.number = n;
    it.base   = b;
    it.drain  = drain;
    pend_q.push_back(it);
    total_items++;
  endtask

  // Driver: offers queued items with a random gap after each accepted item, except the 300th to 359th.
  // An item marked for draining is held back until every expected result has arrived.
  always @(posedge clk_i) begin : driver
    logic       offer;
    pend_item_t cur;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        exp_q.push_back(legendre_exponent(number_i, base_prime_i));
        sent_cnt++;
        offer = 1'b0;
        gap_left = (sent_cnt >= 300 && sent_cnt < 360) ? 0 : $urandom_range(0, 11);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() != 0 && (!pend_q[0].drain || exp_q.size() == 0)) begin
          cur = pend_q.pop_front();
          number_i <= cur.number;
          base_prime_i <= cur.base;
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Monitor: checks each accepted result against the oldest expectation and stalls at random.
  // Twice it holds off for a long stretch so the block fills up and stops taking items.
  always @(posedge clk_i) begin : monitor
    exp_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_cnt++;
        if (exp_q.size() == 0) begin
          report_mismatch($sformatf("result item with nothing expected: exponent=%0d bad_base=%0b",
                                    exponent_o, bad_base_o));
        end else begin
          want = exp_q.pop_front();
          if (exponent_o !== want.exponent)
            report_mismatch($sformatf("result %0d exponent got %0d want %0d",
                                      got_cnt, exponent_o, want.exponent));
          if (bad_base_o !== want.bad_base)
            report_mismatch($sformatf("result %0d bad_base got %0b want %0b",
                                      got_cnt, bad_base_o, want.bad_base));
        end
        stall_left = (got_cnt >= 300 && got_cnt < 360) ? 0 : $urandom_range(0, 11);
        if (got_cnt == 40 || got_cnt == 420) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [W-1:0] n;
    logic [W-1:0] b;
    int unsigned  kind;

    // Bad bases, then the field extremes and the edges of both shortcuts.
    add_item('0, '0, 1'b0);
    add_item(WORD_MAX, '0, 1'b0);
    add_item('0, 1, 1'b0);
    add_item(WORD_MAX, 1, 1'b0);
    add_item(WORD_MAX, 2, 1'b0);
    add_item('0, 2, 1'b0);
    add_item(1, 2, 1'b0);
    add_item(2, 2, 1'b0);
    add_item(4, 2, 1'b0);
    add_item(WORD_MAX, WORD_MAX, 1'b0);
    add_item('0, WORD_MAX, 1'b0);
    add_item(7, 7, 1'b0);
    add_item(10, 5, 1'b0);
    add_item(11, 5, 1'b0);
    add_item(10, 6, 1'b0);
    add_item(100, 4, 1'b0);
    add_item(1000, 10, 1'b0);
    add_item(32'd1000000000, 3, 1'b0);
    add_item(WORD_MAX, 32'h0001_0000, 1'b0);
    add_item(WORD_MAX, 32'h8000_0000, 1'b0);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_item(WORD_MAX, 32'h0000_FFFF, 1'b0);

    // Random items: mostly valid bases of every size, some bad ones, numbers of every size.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) b = $urandom_range(0, 1);
      else if (kind <= 2) b = $urandom_range(2, 16);
      else if (kind <= 5) b = $urandom_range(17, 65535);
      else b = $urandom;
      kind = $urandom_range(0, 9);
      if (kind <= 6) n = $urandom;
      else if (kind <= 8) n = $urandom_range(0, 5000);
      else n = b * $urandom_range(1, 3);
      add_item(n, b, (i == 0 || i == 380));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt != total_items || exp_q.size() != 0) @(posedge clk_i);
    repeat (ITEM_LATENCY) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_factorial_prime_exponent_top: PASS");
    end else begin
      $display("tb_factorial_prime_exponent_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("tb_factorial_prime_exponent_top: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/fpe_pkg.sv
sv/fpe_ctrl.sv
sv/fpe_dp.sv
sv/factorial_prime_exponent_top.sv
sv/fpe_checker.sv
test/tb_factorial_prime_exponent_top.sv
